### rtl/flha_pkg.sv
// Package for the free-list hole allocator: sizes, payload structs, command
// and status structs, codes and the controller state type. No dependencies.
package flha_pkg;

    localparam int MaxHoles = 16;
    localparam int AddrBits = 20;
    localparam int SizeBits = AddrBits + 1;
    localparam int IdxBits  = $clog2(MaxHoles);
    localparam int CntBits  = $clog2(MaxHoles + 1);
    localparam int CfgBits  = 21;
    localparam int CfgIdxBits = 1;

    localparam logic [CfgIdxBits-1:0] CfgFitMode  = 1'd0;
    localparam logic [CfgIdxBits-1:0] CfgPoolSize = 1'd1;

    localparam logic [SizeBits-1:0] PoolLimit = SizeBits'(1) << AddrBits;

    localparam logic [1:0] FitFirst = 2'd0;
    localparam logic [1:0] FitBest  = 2'd1;
    localparam logic [1:0] FitWorst = 2'd2;

    localparam logic [1:0] StOk    = 2'd0;
    localparam logic [1:0] StNoFit = 2'd1;
    localparam logic [1:0] StFull  = 2'd2;

    localparam logic FuncAlloc = 1'b0;
    localparam logic FuncFree  = 1'b1;

    typedef struct packed {
        logic                func;
        logic [SizeBits-1:0] req_size;
        logic [AddrBits-1:0] free_position;
    } req_t;

    typedef struct packed {
        logic [AddrBits-1:0] alloc_position;
        logic [1:0]          status;
        logic [CntBits-1:0]  hole_count;
    } rsp_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_DECIDE,
        S_SHIFT,
        S_DONE
    } ctrl_state_t;

    // Commands from controller to datapath.
    typedef struct packed {
        logic load;
        logic scan_clr;
        logic scan_step;
        logic decide;
        logic shift_step;
        logic rsp_load;
    } cmd_t;

    // Status from datapath to controller.
    typedef struct packed {
        logic scan_last;
        logic need_shift;
        logic shift_last;
    } stat_t;

endpackage

### rtl/free_list_hole_allocator.sv
// Top level of the free-list hole allocator: controller plus datapath.
// Depends on flha_pkg, flha_ctrl and flha_datapath.
//
//   channel  | handshake                 | payload
//   request  | req_valid / req_stall     | req  (req_t)
//   result   | rsp_valid / rsp_stall     | rsp  (rsp_t)
//   config   | cfg_we                    | cfg_idx, cfg_data
//
// A request is accepted, then the hole table is scanned entry by entry, a
// decision is made and, on insert or removal, the table entries are shifted
// one by one; the result then waits in the result register until taken.
// The shift of the hole table is the long path. Reset gives one hole over
// the whole pool. A stalled result holds the block; no new request is taken.
module free_list_hole_allocator
    import flha_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CfgIdxBits-1:0] cfg_idx,
    input  logic [CfgBits-1:0]    cfg_data,
    input  logic                  req_valid,
    output logic                  req_stall,
    input  req_t                  req,
    output logic                  rsp_valid,
    input  logic                  rsp_stall,
    output rsp_t                  rsp
);

    cmd_t  cmd;
    stat_t stat;
    rsp_t  rsp_dp;

    flha_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .stat      (stat),
        .cmd       (cmd)
    );

    flha_datapath u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_idx  (cfg_idx),
        .cfg_data (cfg_data),
        .req      (req),
        .cmd      (cmd),
        .stat     (stat),
        .rsp      (rsp_dp)
    );

    assign rsp = rsp_dp;

endmodule

### rtl/flha_datapath.sv
// Datapath of the free-list hole allocator: hole table, scan registers,
// decision and shift logic. Depends on flha_pkg.
module flha_datapath
    import flha_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CfgIdxBits-1:0] cfg_idx,
    input  logic [CfgBits-1:0]    cfg_data,
    input  req_t                  req,
    input  cmd_t                  cmd,
    output stat_t                 stat,
    output rsp_t                  rsp
);

    logic [AddrBits-1:0] start_reg [MaxHoles];
    logic [SizeBits-1:0] len_reg   [MaxHoles];
    logic [CntBits-1:0]  used_reg;
    logic [1:0]          fit_reg;
    logic [SizeBits-1:0] pool_reg;
    req_t                req_reg;
    logic [CntBits-1:0]  k_reg;
    logic                found_reg;
    logic                done_reg;
    logic [IdxBits-1:0]  pick_reg;
    logic [CntBits-1:0]  pos_reg;
    logic                shdir_reg;
    logic [CntBits-1:0]  sh_reg;
    logic [CntBits-1:0]  shend_reg;
    rsp_t                rsp_reg;

    logic [SizeBits-1:0] clip;
    logic [IdxBits-1:0]  k_idx;
    logic [SizeBits-1:0] k_len;
    logic [AddrBits-1:0] k_start;
    logic                fits;
    logic                better;
    logic                pos_hit;

    assign clip = (cfg_data > CfgBits'(PoolLimit)) ? PoolLimit : cfg_data[SizeBits-1:0];
    assign k_idx   = k_reg[IdxBits-1:0];
    assign k_len   = len_reg[k_idx];
    assign k_start = start_reg[k_idx];
    assign fits    = (k_len >= req_reg.req_size);
    always_comb
    begin
        case (fit_reg)
            FitBest:  better = k_len < len_reg[pick_reg];
            FitWorst: better = k_len > len_reg[pick_reg];
            default:  better = 1'b0;
        endcase
    end
    assign pos_hit = k_start >= req_reg.free_position;

    assign stat.scan_last = (k_reg + CntBits'(1) >= used_reg) || done_reg
                            || (used_reg == '0);

    // Decision on the scanned result.
    logic [IdxBits-1:0]  pi;
    logic [IdxBits-1:0]  pp;
    logic                has_prev;
    logic                has_next;
    logic [SizeBits:0]   prev_end;
    logic [SizeBits:0]   fend;
    logic                jp;
    logic                jn;
    logic [IdxBits-1:0]  pk;

    assign pk       = pick_reg;
    assign pi       = pos_reg[IdxBits-1:0];
    assign pp       = pi - IdxBits'(1);
    assign has_prev = pos_reg != '0;
    assign has_next = pos_reg < used_reg;
    assign prev_end = (SizeBits+1)'(start_reg[pp]) + (SizeBits+1)'(len_reg[pp]);
    assign fend     = (SizeBits+1)'(req_reg.free_position) + (SizeBits+1)'(req_reg.req_size);
    assign jp       = has_prev && (prev_end == (SizeBits+1)'(req_reg.free_position));
    assign jn       = has_next && (fend == (SizeBits+1)'(start_reg[pi]));

    logic [1:0] d_status;
    logic       d_rm;
    logic       d_ins;
    logic [CntBits-1:0] d_at;
    logic [AddrBits-1:0] d_apos;

    always_comb
    begin
        d_status = StOk;
        d_rm     = 1'b0;
        d_ins    = 1'b0;
        d_at     = '0;
        d_apos   = '0;
        if (req_reg.func == FuncAlloc)
        begin
            if (req_reg.req_size == '0 || !found_reg)
            begin
                d_status = StNoFit;
            end
            else
            begin
                d_apos = start_reg[pk];
                if (len_reg[pk] == req_reg.req_size)
                begin
                    d_rm = 1'b1;
                    d_at = CntBits'(pk);
                end
            end
        end
        else if (req_reg.req_size != '0)
        begin
            if (fend > (SizeBits+1)'(pool_reg))
                d_status = StNoFit;
            else if (has_prev && prev_end > (SizeBits+1)'(req_reg.free_position))
                d_status = StNoFit;
            else if (has_next && fend > (SizeBits+1)'(start_reg[pi]))
                d_status = StNoFit;
            else if (jp && jn)
            begin
                d_rm = 1'b1;
                d_at = pos_reg;
            end
            else if (!jp && !jn)
            begin
                if (used_reg >= CntBits'(MaxHoles))
                    d_status = StFull;
                else
                begin
                    d_ins = 1'b1;
                    d_at  = pos_reg;
                end
            end
        end
    end

    assign stat.need_shift = d_rm || d_ins;
    assign stat.shift_last = shdir_reg ? (sh_reg <= shend_reg)
                                       : (sh_reg + CntBits'(1) >= shend_reg);

    logic [IdxBits-1:0] si;
    logic [IdxBits-1:0] sn;
    assign si = sh_reg[IdxBits-1:0];
    assign sn = shdir_reg ? si - IdxBits'(1) : si + IdxBits'(1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fit_reg  <= FitFirst;
            pool_reg <= PoolLimit;
            used_reg <= CntBits'(1);
            for (int i = 0; i < MaxHoles; i++)
            begin
                start_reg[i] <= '0;
                len_reg[i]   <= '0;
            end
            len_reg[0] <= PoolLimit;
        end
        else if (cfg_we)
        begin
            if (cfg_idx == CfgFitMode)
                fit_reg <= cfg_data[1:0];
            else if (cfg_idx == CfgPoolSize)
            begin
                pool_reg <= clip;
                for (int i = 0; i < MaxHoles; i++)
                begin
                    start_reg[i] <= '0;
                    len_reg[i]   <= '0;
                end
                len_reg[0] <= clip;
                used_reg   <= (clip == '0) ? '0 : CntBits'(1);
            end
        end
        else if (cmd.decide && d_status == StOk)
        begin
            if (req_reg.func == FuncAlloc)
            begin
                if (!d_rm)
                begin
                    start_reg[pk] <= start_reg[pk] + req_reg.req_size[AddrBits-1:0];
                    len_reg[pk]   <= len_reg[pk] - req_reg.req_size;
                end
            end
            else if (req_reg.req_size != '0)
            begin
                if (jp && jn)
                    len_reg[pp] <= len_reg[pp] + req_reg.req_size + len_reg[pi];
                else if (jn)
                begin
                    start_reg[pi] <= req_reg.free_position;
                    len_reg[pi]   <= len_reg[pi] + req_reg.req_size;
                end
                else if (jp)
                    len_reg[pp] <= len_reg[pp] + req_reg.req_size;
            end
            if (d_ins)
                used_reg <= used_reg + CntBits'(1);
        end
        else if (cmd.shift_step)
        begin
            if (shdir_reg)
            begin
                if (sh_reg <= shend_reg)
                begin
                    start_reg[si] <= req_reg.free_position;
                    len_reg[si]   <= req_reg.req_size;
                end
                else
                begin
                    start_reg[si] <= start_reg[sn];
                    len_reg[si]   <= len_reg[sn];
                end
            end
            else if (sh_reg + CntBits'(1) >= shend_reg)
            begin
                start_reg[si] <= '0;
                len_reg[si]   <= '0;
                used_reg      <= used_reg - CntBits'(1);
            end
            else
            begin
                start_reg[si] <= start_reg[sn];
                len_reg[si]   <= len_reg[sn];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_reg   <= '0;
            k_reg     <= '0;
            found_reg <= 1'b0;
            done_reg  <= 1'b0;
            pick_reg  <= '0;
            pos_reg   <= '0;
            shdir_reg <= 1'b0;
            sh_reg    <= '0;
            shend_reg <= '0;
            rsp_reg   <= '0;
        end
        else
        begin
            if (cmd.load)
                req_reg <= req;
            if (cmd.scan_clr)
            begin
                k_reg     <= '0;
                found_reg <= 1'b0;
                done_reg  <= (used_reg == '0);
                pos_reg   <= used_reg;
            end
            else if (cmd.scan_step && !done_reg)
            begin
                k_reg <= k_reg + CntBits'(1);
                if (req_reg.func == FuncAlloc)
                begin
                    if (fits && (!found_reg || better))
                    begin
                        pick_reg  <= k_idx;
                        found_reg <= 1'b1;
                        if (fit_reg != FitBest && fit_reg != FitWorst)
                            done_reg <= 1'b1;
                    end
                end
                else if (pos_hit)
                begin
                    pos_reg  <= k_reg;
                    done_reg <= 1'b1;
                end
            end
            if (cmd.decide)
            begin
                shdir_reg <= d_ins;
                if (d_ins)
                begin
                    sh_reg    <= used_reg;
                    shend_reg <= d_at;
                end
                else
                begin
                    sh_reg    <= d_at;
                    shend_reg <= used_reg;
                end
                rsp_reg.alloc_position <= d_apos;
                rsp_reg.status         <= d_status;
            end
            else if (cmd.shift_step)
                sh_reg <= shdir_reg ? sh_reg - CntBits'(1) : sh_reg + CntBits'(1);
            if (cmd.rsp_load)
                rsp_reg.hole_count <= (cmd.shift_step && !shdir_reg)
                                      ? used_reg - CntBits'(1) : used_reg;
        end
    end

    assign rsp = rsp_reg;

endmodule

### rtl/flha_ctrl.sv
// Controller of the free-list hole allocator: request handshake, sequencing
// of scan, decision and shift, result handshake. Depends on flha_pkg.
module flha_ctrl
    import flha_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  req_valid,
    output logic  req_stall,
    output logic  rsp_valid,
    input  logic  rsp_stall,
    input  stat_t stat,
    output cmd_t  cmd
);

    ctrl_state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        req_stall  = 1'b1;
        rsp_valid  = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                req_stall = 1'b0;
                if (req_valid)
                begin
                    cmd.load     = 1'b1;
                    cmd.scan_clr = 1'b1;
                    state_next   = S_SCAN;
                end
            end
            S_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (stat.scan_last)
                    state_next = S_DECIDE;
            end
            S_DECIDE:
            begin
                cmd.decide = 1'b1;
                if (stat.need_shift)
                    state_next = S_SHIFT;
                else
                begin
                    cmd.rsp_load = 1'b1;
                    state_next   = S_DONE;
                end
            end
            S_SHIFT:
            begin
                cmd.shift_step = 1'b1;
                if (stat.shift_last)
                begin
                    cmd.rsp_load = 1'b1;
                    state_next   = S_DONE;
                end
            end
            S_DONE:
            begin
                rsp_valid = 1'b1;
                if (!rsp_stall)
                    state_next = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

endmodule

### rtl/flha_checker.sv
// Port-level checker for the free-list hole allocator, bound to the top level.
// Depends on flha_pkg.
module flha_checker
    import flha_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input logic req_valid,
    input logic req_stall,
    input logic rsp_valid,
    input logic rsp_stall,
    input rsp_t rsp
);

    // A result that waits does not change.
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
        else $error("result changed while stalled");

    // The block never takes a request while a result is shown.
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> req_stall)
        else $error("request taken while result pending");

    // A request taken leads to no result in the next cycle.
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_stall |=> !rsp_valid)
        else $error("result too early");

    // The reported status is one of the defined codes and the hole count is at most MaxHoles.
    a_status: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> rsp.status <= StFull && rsp.hole_count <= CntBits'(MaxHoles))
        else $error("bad result fields");

endmodule

bind free_list_hole_allocator flha_checker u_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
);
